[rtl/spectrum_peak_top_finder_core_macros.svh]
// ----------------------------------------------------------------------------
// Spectrum peak-top finder assertion macros
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_PEAK_TOP_FINDER_CORE_MACROS_SVH
`define SPECTRUM_PEAK_TOP_FINDER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SPF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spectrum peak finder check failed");

// next-cycle implication
`define SPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spectrum peak finder check failed");

`else

`define SPF_ASSERT_NOW(lbl, ante, cons)
`define SPF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/spf_pkg.sv]
// ----------------------------------------------------------------------------
// Spectrum peak-top finder package
// Sizes, action codes, sequencer states and compare-unit types.
// ----------------------------------------------------------------------------
`default_nettype none

package spf_pkg;

  // spectrum store
  localparam int unsigned SPF_DEPTH = 4096;
  localparam int unsigned SPF_IDX_W = $clog2(SPF_DEPTH);
  localparam int unsigned SPF_CNT_W = SPF_IDX_W + 1;
  localparam int unsigned SPF_VAL_W = 32;

  // stream widths
  localparam int unsigned SPF_IN_DATA_W  = 64;
  localparam int unsigned SPF_IN_USER_W  = 2;
  localparam int unsigned SPF_OUT_DATA_W = 24;
  localparam int unsigned SPF_OUT_USER_W = 1;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_CLEAR  = 2'd2
  } spf_action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_PICK,
    ST_DIST_LO,
    ST_DIST_HI,
    ST_DIST_SEL,
    ST_NB_PREV,
    ST_NB_NEXT,
    ST_NB_DIR,
    ST_CLIMB_RD,
    ST_CLIMB_CMP,
    ST_DONE
  } spf_state_e;

  // request to the shared compare unit
  typedef struct packed {
    logic [SPF_VAL_W-1:0] op_a;
    logic [SPF_VAL_W-1:0] op_b;
    logic                 is_signed;
  } spf_alu_req_t;

  // compare unit answer
  typedef struct packed {
    logic                 lt;    // op_a < op_b
    logic                 eq;    // op_a == op_b
    logic [SPF_VAL_W-1:0] diff;  // |op_a - op_b|, unsigned
  } spf_alu_rsp_t;

endpackage

`default_nettype wire

[rtl/spectrum_peak_top_finder_core.sv]
// Spectrum peak-top finder. Append and clear items are taken in the idle
// state. A query runs on a store with one write port, one registered read
// port and one shared compare unit: a binary search (up to 13 steps for 4096
// entries), a pick of the nearest entry, a read of both neighbors, a hill
// climb with one read and one compare per step, and a load of the result
// into the output register once it is free. The climb is skipped when the
// two neighbors are equal; smaller stores need fewer search steps. Empty and
// one-entry queries go straight to the result load. The input is not ready
// while a query runs; a finished result waits in the output register while
// the next item is taken.
// ----------------------------------------------------------------------------
// Spectrum peak-top finder core
// Sorted m/z store with nearest search and hill climb to the intensity peak.
// ----------------------------------------------------------------------------
`default_nettype none
`include "spectrum_peak_top_finder_core_macros.svh"

module spectrum_peak_top_finder_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input items
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [31:0] mz_value, [63:32] intensity_value
  input  logic [spf_pkg::SPF_IN_DATA_W-1:0]   s_axis_tdata,
  // [1:0] action
  input  logic [spf_pkg::SPF_IN_USER_W-1:0]   s_axis_tuser,
  // result items
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [11:0] nearest_index, [23:12] peak_top_index
  output logic [spf_pkg::SPF_OUT_DATA_W-1:0]  m_axis_tdata,
  // [0] status
  output logic [spf_pkg::SPF_OUT_USER_W-1:0]  m_axis_tuser
);
  import spf_pkg::*;

  localparam logic [SPF_CNT_W-1:0] DepthCnt = SPF_CNT_W'(SPF_DEPTH);

  // control state
  spf_state_e           state_q, state_d;
  logic [SPF_CNT_W-1:0] cnt_q, cnt_d;
  logic                 ovld_q, ovld_d;

  // datapath registers
  logic [SPF_CNT_W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [SPF_VAL_W-1:0] tgt_q, tgt_d;
  logic [SPF_IDX_W-1:0] hit_q, hit_d, top_q, top_d;
  logic                 below_q, below_d, up_q, up_d, stat_q, stat_d;
  logic [SPF_VAL_W-1:0] va_q, va_d, vb_q, vb_d, cur_q, cur_d;
  logic [SPF_IDX_W-1:0] onear_q, onear_d, otop_q, otop_d;
  logic                 ostat_q, ostat_d;

  // store ports
  logic [SPF_VAL_W-1:0] mz_mem [SPF_DEPTH];
  logic [SPF_VAL_W-1:0] in_mem [SPF_DEPTH];
  logic [SPF_VAL_W-1:0] mz_rd_q, in_rd_q;
  logic [SPF_IDX_W-1:0] rd_addr;
  logic                 wr_en;

  // shared compare unit
  spf_alu_req_t         alu_req;
  spf_alu_rsp_t         alu_rsp;

  logic                 in_fire;
  logic [SPF_CNT_W:0]   mid_sum;
  logic [SPF_IDX_W-1:0] mid;
  logic [SPF_IDX_W-1:0] last_idx;
  logic [SPF_CNT_W-1:0] lo_n, hi_n;
  logic [SPF_VAL_W-1:0] in_mz, in_int;
  spf_action_e          in_act;

  assign in_mz   = s_axis_tdata[SPF_VAL_W-1:0];
  assign in_int  = s_axis_tdata[2*SPF_VAL_W-1:SPF_VAL_W];
  assign in_act  = spf_action_e'(s_axis_tuser);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {otop_q, onear_q};
  assign m_axis_tuser  = ostat_q;

  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = mid_sum[SPF_IDX_W:1];
  assign last_idx = cnt_q[SPF_IDX_W-1:0] - 1'b1;

  spf_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mz_mem[cnt_q[SPF_IDX_W-1:0]] <= in_mz;
      in_mem[cnt_q[SPF_IDX_W-1:0]] <= in_int;
    end
    mz_rd_q <= mz_mem[rd_addr];
    in_rd_q <= in_mem[rd_addr];
  end

  // sequencer: next state and datapath updates
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ovld_d  = ovld_q && !m_axis_tready;
    lo_d    = lo_q;
    hi_d    = hi_q;
    tgt_d   = tgt_q;
    hit_d   = hit_q;
    top_d   = top_q;
    below_d = below_q;
    up_d    = up_q;
    stat_d  = stat_q;
    va_d    = va_q;
    vb_d    = vb_q;
    cur_d   = cur_q;
    onear_d = onear_q;
    otop_d  = otop_q;
    ostat_d = ostat_q;
    rd_addr = mid;
    wr_en   = 1'b0;
    lo_n    = lo_q;
    hi_n    = hi_q;
    alu_req = '{op_a: mz_rd_q, op_b: tgt_q, is_signed: 1'b0};

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_act)
            ACT_APPEND: begin
              if (cnt_q < DepthCnt) begin
                wr_en = 1'b1;
                cnt_d = cnt_q + 1'b1;
              end
            end
            ACT_CLEAR: cnt_d = '0;
            ACT_QUERY: begin
              tgt_d  = in_mz;
              lo_d   = '0;
              hi_d   = cnt_q;
              hit_d  = '0;
              top_d  = '0;
              stat_d = (cnt_q == '0);
              if (cnt_q < SPF_CNT_W'(2)) state_d = ST_DONE;
              else                       state_d = ST_SRCH_RD;
            end
            default: ;
          endcase
        end
      end

      // binary search for the first entry >= target
      ST_SRCH_RD: begin
        rd_addr = mid;
        state_d = ST_SRCH_CMP;
      end

      ST_SRCH_CMP: begin
        if (alu_rsp.lt) lo_n = {1'b0, mid} + 1'b1;
        else            hi_n = {1'b0, mid};
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n < hi_n) state_d = ST_SRCH_RD;
        else             state_d = ST_PICK;
      end

      // edges of the store need no distance check
      ST_PICK: begin
        rd_addr = lo_q[SPF_IDX_W-1:0] - 1'b1;
        if (lo_q == '0) begin
          hit_d   = '0;
          below_d = 1'b0;
          state_d = ST_NB_PREV;
        end else if (lo_q >= cnt_q) begin
          hit_d   = last_idx;
          below_d = 1'b1;
          state_d = ST_NB_PREV;
        end else begin
          state_d = ST_DIST_LO;
        end
      end

      ST_DIST_LO: begin
        alu_req = '{op_a: tgt_q, op_b: mz_rd_q, is_signed: 1'b0};
        va_d    = alu_rsp.diff;
        rd_addr = lo_q[SPF_IDX_W-1:0];
        state_d = ST_DIST_HI;
      end

      ST_DIST_HI: begin
        vb_d    = alu_rsp.diff;
        state_d = ST_DIST_SEL;
      end

      // on equal distance the lower entry wins
      ST_DIST_SEL: begin
        alu_req = '{op_a: vb_q, op_b: va_q, is_signed: 1'b0};
        if (alu_rsp.lt) begin
          hit_d   = lo_q[SPF_IDX_W-1:0];
          below_d = 1'b0;
        end else begin
          hit_d   = lo_q[SPF_IDX_W-1:0] - 1'b1;
          below_d = 1'b1;
        end
        state_d = ST_NB_PREV;
      end

      // read both neighbors on the target's side
      ST_NB_PREV: begin
        top_d = hit_q;
        if (below_q || hit_q == '0) rd_addr = hit_q;
        else                        rd_addr = hit_q - 1'b1;
        state_d = ST_NB_NEXT;
      end

      ST_NB_NEXT: begin
        va_d = in_rd_q;
        if (below_q && hit_q != last_idx) rd_addr = hit_q + 1'b1;
        else                              rd_addr = hit_q;
        state_d = ST_NB_DIR;
      end

      ST_NB_DIR: begin
        alu_req = '{op_a: va_q, op_b: in_rd_q, is_signed: 1'b1};
        cur_d   = below_q ? va_q : in_rd_q;
        up_d    = alu_rsp.lt;
        if (alu_rsp.eq) state_d = ST_DONE;
        else            state_d = ST_CLIMB_RD;
      end

      // hill climb while the neighbor is strictly higher
      ST_CLIMB_RD: begin
        if (up_q) rd_addr = top_q + 1'b1;
        else      rd_addr = top_q - 1'b1;
        if ((up_q && top_q == last_idx) || (!up_q && top_q == '0)) state_d = ST_DONE;
        else                                                         state_d = ST_CLIMB_CMP;
      end

      ST_CLIMB_CMP: begin
        alu_req = '{op_a: cur_q, op_b: in_rd_q, is_signed: 1'b1};
        if (alu_rsp.lt) begin
          top_d   = up_q ? top_q + 1'b1 : top_q - 1'b1;
          cur_d   = in_rd_q;
          state_d = ST_CLIMB_RD;
        end else begin
          state_d = ST_DONE;
        end
      end

      // hand the result to the output register once it is free
      ST_DONE: begin
        if (!ovld_q || m_axis_tready) begin
          ovld_d  = 1'b1;
          onear_d = hit_q;
          otop_d  = top_q;
          ostat_d = stat_q;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovld_q  <= ovld_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    tgt_q   <= tgt_d;
    hit_q   <= hit_d;
    top_q   <= top_d;
    below_q <= below_d;
    up_q    <= up_d;
    stat_q  <= stat_d;
    va_q    <= va_d;
    vb_q    <= vb_d;
    cur_q   <= cur_d;
    onear_q <= onear_d;
    otop_q  <= otop_d;
    ostat_q <= ostat_d;
  end

  // checks
  `SPF_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= DepthCnt)
  `SPF_ASSERT_NOW(a_srch_range, state_q == ST_SRCH_RD, (lo_q < hi_q) && (hi_q <= cnt_q))
  `SPF_ASSERT_NOW(a_climb_range, state_q == ST_CLIMB_RD, SPF_CNT_W'(top_q) < cnt_q)
  `SPF_ASSERT_NEXT(a_out_source, !ovld_q && state_q != ST_DONE, !ovld_q)

endmodule

`default_nettype wire

[rtl/spf_alu.sv]
// ----------------------------------------------------------------------------
// Spectrum peak-top finder compare unit
// Shared less-than / equal / absolute-distance unit used by every compare step.
// ----------------------------------------------------------------------------
`default_nettype none

module spf_alu (
  input  spf_pkg::spf_alu_req_t req_i,
  output spf_pkg::spf_alu_rsp_t rsp_o
);
  import spf_pkg::*;

  logic [SPF_VAL_W-1:0] flip;
  logic [SPF_VAL_W:0]   sub_ab;
  logic [SPF_VAL_W:0]   sub_ba;

  // signed compare by flipping the sign bit
  assign flip = {req_i.is_signed, {(SPF_VAL_W-1){1'b0}}};

  assign rsp_o.lt = (req_i.op_a ^ flip) < (req_i.op_b ^ flip);
  assign rsp_o.eq = (req_i.op_a == req_i.op_b);

  // absolute distance: pick the subtraction that does not borrow
  assign sub_ab = {1'b0, req_i.op_a} - {1'b0, req_i.op_b};
  assign sub_ba = {1'b0, req_i.op_b} - {1'b0, req_i.op_a};
  assign rsp_o.diff = sub_ab[SPF_VAL_W] ? sub_ba[SPF_VAL_W-1:0] : sub_ab[SPF_VAL_W-1:0];

endmodule

`default_nettype wire

[dv/spectrum_peak_top_finder_core_test.sv]
// ----------------------------------------------------------------------------
// Spectrum peak-top finder core testbench
// Streams append, clear and query items into the core and checks every query
// result against a local model of the sorted store, the nearest search and
// the intensity hill climb. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module spectrum_peak_top_finder_core_test;
  import spf_pkg::*;

  // action code with no meaning to the core; it must be dropped silently
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [SPF_IDX_W-1:0] nearest;
    logic [SPF_IDX_W-1:0] peak;
    logic                 status;
  } peak_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [SPF_IN_DATA_W-1:0]  s_axis_tdata;   // [31:0] mz_value, [63:32] intensity_value
  logic [SPF_IN_USER_W-1:0]  s_axis_tuser;   // [1:0] action
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [SPF_OUT_DATA_W-1:0] m_axis_tdata;   // [11:0] nearest_index, [23:12] peak_top_index
  logic [SPF_OUT_USER_W-1:0] m_axis_tuser;   // [0] status

  // local copy of the spectrum store
  logic        [31:0] spec_mz  [SPF_DEPTH];
  logic signed [31:0] spec_int [SPF_DEPTH];
  int unsigned        spec_len = 0;

  peak_result_t expected_peaks[$];
  int unsigned  err_count     = 0;
  int unsigned  items_sent    = 0;
  bit           tx_idle_en    = 1'b1;
  bit           rx_idle_en    = 1'b1;
  int unsigned  rx_hold_cycles = 0;

  spectrum_peak_top_finder_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // safety net against a hung handshake
  initial begin : run_limit
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Store update and peak search for one accepted item
  function automatic void predict_item(logic [1:0] act, logic [31:0] mz, logic [31:0] inten);
    peak_result_t res;
    int unsigned  n, lo, hi, mid, hit, prv, nxt, top;
    logic [31:0]  d_lo, d_hi;
    case (act)
      ACT_APPEND: begin
        // full store drops the entry
        if (spec_len < SPF_DEPTH) begin
          spec_mz[spec_len]  = mz;
          spec_int[spec_len] = inten;
          spec_len++;
        end
      end
      ACT_CLEAR: begin
        spec_len = 0;
      end
      ACT_QUERY: begin
        n   = spec_len;
        res = '0;
        if (n == 0) begin
          res.status = 1'b1;
        end else if (n > 1) begin
          // first index with m/z >= target
          lo = 0;
          hi = n;
          while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (spec_mz[mid] < mz) lo = mid + 1;
            else hi = mid;
          end
          if (lo == 0) begin
            hit = 0;
          end else if (lo >= n) begin
            hit = n - 1;
          end else begin
            // equal distance goes to the lower index
            d_lo = mz - spec_mz[lo-1];
            d_hi = spec_mz[lo] - mz;
            hit  = (d_lo <= d_hi) ? lo - 1 : lo;
          end
          // neighbors on the target's side
          if (spec_mz[hit] < mz) begin
            prv = hit;
            nxt = (hit == n - 1) ? hit : hit + 1;
          end else begin
            nxt = hit;
            prv = (hit == 0) ? 0 : hit - 1;
          end
          // climb toward the higher neighbor
          top = hit;
          if (spec_int[prv] < spec_int[nxt]) begin
            while (top < n - 1 && spec_int[top] < spec_int[top+1]) top++;
          end else if (spec_int[nxt] < spec_int[prv]) begin
            while (top > 0 && spec_int[top] < spec_int[top-1]) top--;
          end
          res.nearest = hit[SPF_IDX_W-1:0];
          res.peak    = top[SPF_IDX_W-1:0];
        end
        expected_peaks.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // Offer one item after a random gap and wait for it to be taken
  task automatic send_item(input logic [1:0] act, input logic [31:0] mz,
                           input logic [31:0] inten);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {inten, mz};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_item(act, mz, inten);
    if (act != ACT_UNKNOWN) items_sent++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_peaks.size() != 0);
  endtask

  // Result side: random ready gaps plus an optional long hold-off
  initial begin : result_sink
    int unsigned gap;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = rx_hold_cycles + (rx_idle_en ? $urandom_range(0, 14) : 0);
      rx_hold_cycles = 0;
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk_i);
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    peak_result_t exp_r;
    if (rst_ni === 1'b1 && m_axis_tvalid && m_axis_tready) begin
      if (expected_peaks.size() == 0) begin
        $display("%0t: unexpected result nearest=%0d peak=%0d status=%0d", $time,
                 m_axis_tdata[11:0], m_axis_tdata[23:12], m_axis_tuser[0]);
        err_count++;
      end else begin
        exp_r = expected_peaks.pop_front();
        if (m_axis_tdata[11:0] !== exp_r.nearest) begin
          $display("%0t: nearest_index expected %0d actual %0d", $time,
                   exp_r.nearest, m_axis_tdata[11:0]);
          err_count++;
        end
        if (m_axis_tdata[23:12] !== exp_r.peak) begin
          $display("%0t: peak_top_index expected %0d actual %0d", $time,
                   exp_r.peak, m_axis_tdata[23:12]);
          err_count++;
        end
        if (m_axis_tuser[0] !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_r.status, m_axis_tuser[0]);
          err_count++;
        end
      end
    end
  end

  // Query with nothing loaded, clear the empty store, then query again
  task automatic test_empty_spectrum();
    send_item(ACT_QUERY, 32'hFFFF_FFFF, 32'h8000_0000);
    send_item(ACT_CLEAR, 32'h0, 32'h0);
    send_item(ACT_QUERY, 32'h0, 32'h7FFF_FFFF);
    wait_idle();
  endtask

  // One entry always answers index zero
  task automatic test_single_entry();
    send_item(ACT_APPEND, 32'h0010_0000, 32'h0000_0005);
    send_item(ACT_QUERY, 32'h0000_0000, 32'h0);
    send_item(ACT_QUERY, 32'h0010_0000, 32'h0);
    send_item(ACT_QUERY, 32'hFFFF_FFFF, 32'h0);
    wait_idle();
  endtask

  // Field extremes, ties, clamping at the low end, all climb directions
  task automatic test_nearest_and_climb();
    send_item(ACT_CLEAR, 32'h0, 32'h0);
    send_item(ACT_APPEND, 32'h0000_0000, 32'h8000_0000);
    send_item(ACT_APPEND, 32'h000A_0000, 32'h0000_0005);
    send_item(ACT_APPEND, 32'h0014_0000, 32'h0000_0009);
    send_item(ACT_APPEND, 32'h001E_0000, 32'h0000_0009);
    send_item(ACT_APPEND, 32'h0028_0000, 32'h7FFF_FFFF);
    send_item(ACT_APPEND, 32'h0032_0000, 32'hFFFF_FFFD);
    send_item(ACT_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFD);
    send_item(ACT_QUERY, 32'h0000_0000, 32'h0);   // below/at first entry
    send_item(ACT_QUERY, 32'h000F_0000, 32'h0);   // tie between two entries
    send_item(ACT_QUERY, 32'h001E_0000, 32'h0);   // exact hit, plateau
    send_item(ACT_QUERY, 32'h0031_0000, 32'h0);   // falling side
    send_item(ACT_QUERY, 32'hFFFF_FFFF, 32'h0);   // top end, equal neighbors
    send_item(ACT_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ACT_QUERY, 32'h8000_0000, 32'hFFFF_FFFF);
    wait_idle();
  endtask

  // Fill the whole store, long climbs, then one dropped append
  task automatic test_store_full();
    logic [31:0] inten;
    tx_idle_en = 1'b0;
    send_item(ACT_CLEAR, 32'h0, 32'h0);
    for (int unsigned i = 0; i < SPF_DEPTH; i++) begin
      inten = (i < 3000) ? i : 6000 - i;
      send_item(ACT_APPEND, (i << 16) | $urandom_range(0, 16'hFFFF), inten);
    end
    send_item(ACT_QUERY, 32'h0000_0000, 32'h0);
    send_item(ACT_QUERY, 32'h0000_FFFF, 32'h0);
    send_item(ACT_QUERY, 32'hFFFF_FFFF, 32'h0);
    send_item(ACT_QUERY, 32'h0800_8000, 32'h0);
    // store is full: this append must not land
    send_item(ACT_APPEND, 32'h0000_0000, 32'h7FFF_FFFF);
    send_item(ACT_QUERY, 32'hFFFF_FFFF, 32'h0);
    send_item(ACT_CLEAR, 32'h0, 32'h0);
    tx_idle_en = 1'b1;
    wait_idle();
  endtask

  // Receiver holds off while queries keep coming; sender then pauses
  task automatic test_backpressure();
    send_item(ACT_CLEAR, 32'h0, 32'h0);
    for (int unsigned i = 0; i < 16; i++)
      send_item(ACT_APPEND, i << 18, $urandom_range(0, 6) - 3);
    wait_idle();
    tx_idle_en = 1'b0;
    rx_hold_cycles = 500;
    for (int unsigned i = 0; i < 10; i++)
      send_item(ACT_QUERY, $urandom_range(0, 32'h0040_0000), 32'h0);
    wait_idle();
    tx_idle_en = 1'b1;
    for (int unsigned i = 0; i < 4; i++)
      send_item(ACT_QUERY, $urandom, 32'h0);
    wait_idle();
  endtask

  // Random spectra: mostly sorted loads with queries, some noise
  task automatic test_random_spectra();
    int unsigned n, nq, j, shift, pick, shape, cpos, stop_at;
    bit          messy;
    logic [32:0] acc;
    logic [31:0] mz, inten, tgt;
    stop_at = items_sent + 950;
    while (items_sent < stop_at) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      messy      = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 7) != 0) send_item(ACT_CLEAR, $urandom, $urandom);

      // spectrum size: mostly small, a few empty, single or larger
      pick = $urandom_range(0, 19);
      if (pick == 0)      n = 0;
      else if (pick == 1) n = 1;
      else if (pick == 2) n = $urandom_range(64, 300);
      else                n = $urandom_range(2, 40);

      acc   = {1'b0, $urandom >> $urandom_range(0, 31)};
      shift = $urandom_range(0, 30);
      shape = $urandom_range(0, 2);
      cpos  = (n > 0) ? $urandom_range(0, n - 1) : 0;
      for (j = 0; j < n; j++) begin
        mz = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
        if (messy && $urandom_range(0, 7) == 0) mz = $urandom;
        case (shape)
          0:       inten = $urandom_range(0, 6) - 3;
          1:       inten = $urandom;
          default: inten = ((j <= cpos) ? j : 2 * cpos - j) * 50 + $urandom_range(0, 60);
        endcase
        send_item(ACT_APPEND, mz, inten);
        if (messy && $urandom_range(0, 15) == 0) send_item(ACT_UNKNOWN, $urandom, $urandom);
        acc = acc + ($urandom & ((32'd1 << shift) - 32'd1));
        if (acc[32]) acc = 33'h0_FFFF_FFFF;
      end

      nq = $urandom_range(1, 5);
      for (int unsigned q = 0; q < nq; q++) begin
        j    = (spec_len > 0) ? $urandom_range(0, spec_len - 1) : 0;
        pick = (spec_len > 0) ? $urandom_range(0, 6) : 4;
        case (pick)
          0: tgt = spec_mz[j];
          1: tgt = spec_mz[j] + $urandom_range(1, 1 << $urandom_range(0, 20));
          2: tgt = spec_mz[j] - $urandom_range(1, 1 << $urandom_range(0, 20));
          3: begin
            if (j + 1 < spec_len)
              tgt = 32'(({1'b0, spec_mz[j]} + {1'b0, spec_mz[j+1]}) >> 1);
            else tgt = spec_mz[j];
          end
          5:       tgt = 32'h0;
          6:       tgt = 32'hFFFF_FFFF;
          default: tgt = $urandom;
        endcase
        send_item(ACT_QUERY, tgt, $urandom);
        if (messy && $urandom_range(0, 5) == 0)
          send_item(ACT_APPEND, $urandom, $urandom);
      end
      // now and then let everything drain between spectra
      if ($urandom_range(0, 9) == 0) wait_idle();
    end
    wait_idle();
  endtask

  initial begin : main_seq
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ACT_APPEND;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_spectrum();
    test_single_entry();
    test_nearest_and_climb();
    test_store_full();
    test_backpressure();
    test_random_spectra();

    // catch stray results after the last expected one
    repeat (100) @(posedge clk_i);
    if (err_count == 0 && expected_peaks.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[spectrum_peak_top_finder_core.f]
+incdir+rtl
rtl/spf_pkg.sv
rtl/spf_alu.sv
rtl/spectrum_peak_top_finder_core.sv
dv/spectrum_peak_top_finder_core_test.sv
